[rtl/kfsa_pkg.sv]
// kfsa_pkg: shared constants and controller/datapath interface types
// for the k-th free slot allocator; no dependencies
`timescale 1ns / 1ps

package kfsa_pkg;

    // slot row size, a power of two; the count tree is a full binary heap over it
    localparam int SLOTS    = 1024;
    localparam int LEVELS   = $clog2(SLOTS);
    localparam int NODE_W   = LEVELS + 1;      // heap index 1 .. 2*SLOTS-1
    localparam int CNT_W    = LEVELS + 1;      // count 0 .. SLOTS
    localparam int TREE_LEN = 2 * SLOTS;

    // port widths
    localparam int RANK_W = 10;
    localparam int SLOT_W = 10;
    localparam int FREE_W = 11;
    localparam int CFG_W  = 11;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;    // write one init entry of the sweep and advance
        logic load_item;   // latch rank, read root
        logic take_root;   // capture root count, check rank
        logic step_write;  // write decremented count of current node
        logic read_left;   // read left child of current node
        logic descend;     // pick child from left count
        logic out_load;    // load result register
    } kfsa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;    // sweep is at its final entry
        logic over_rank;   // rank not below root count
        logic at_leaf;     // current node is a leaf
        logic out_busy;    // result register full and not taken this cycle
    } kfsa_sts_t;

endpackage

[rtl/kfsa_ctrl.sv]
// kfsa_ctrl: sequencer for init sweep, root check and tree descent
// depends on kfsa_pkg
`timescale 1ns / 1ps

module kfsa_ctrl
    import kfsa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      cfg_fire,
    input  kfsa_sts_t sts,
    output logic      s_ready,
    output kfsa_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_STEP_RD,
        ST_STEP_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = !cfg_fire;
                if (!cfg_fire && sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.take_root = 1'b1;
                state_next    = sts.over_rank ? ST_FINISH : ST_STEP_RD;
            end
            ST_STEP_RD: begin
                cmd.step_write = 1'b1;
                if (sts.at_leaf) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.read_left = 1'b1;
                    state_next    = ST_STEP_WAIT;
                end
            end
            ST_STEP_WAIT: begin
                cmd.descend = 1'b1;
                state_next  = ST_STEP_RD;
            end
            ST_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
        // a register write always restarts the sweep
        if (cfg_fire) begin
            state_next = ST_CLEAR;
        end
        s_ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

[rtl/kfsa_dp.sv]
// kfsa_dp: count tree memory, init sweep generator, descent registers
// and result register; depends on kfsa_pkg
`timescale 1ns / 1ps

module kfsa_dp
    import kfsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  kfsa_cmd_t         cmd,
    input  logic              cfg_fire,
    input  logic [CFG_W-1:0]  cfg_slot_count,
    input  logic [RANK_W-1:0] s_rank,
    input  logic              m_ready,
    output kfsa_sts_t         sts,
    output logic              m_valid,
    output logic [SLOT_W-1:0] m_slot,
    output logic              m_fault,
    output logic [FREE_W-1:0] m_free_left
);

    // count tree, heap order, entry 0 unused
    logic [CNT_W-1:0] tree_mem [TREE_LEN];
    logic [CNT_W-1:0] rd_data_reg;

    // slot count, saturated
    logic [CNT_W-1:0] n_reg, n_next;

    // init sweep
    logic [NODE_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]  size_reg, size_next;
    logic [CNT_W-1:0]  init_val;
    logic [CNT_W-1:0]  base_end;

    // descent
    logic [CNT_W-1:0]  k_reg;
    logic [NODE_W-1:0] node_reg;
    logic [CNT_W-1:0]  cur_reg;
    logic [CNT_W-1:0]  total_reg;
    logic              fault_reg;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0] m_slot_reg;
    logic              m_fault_reg;
    logic [FREE_W-1:0] m_free_left_reg;

    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [NODE_W-1:0] mem_raddr;
    logic              go_left;

    // free slots of n under node [base, base+size)
    always_comb begin
        if (n_reg > base_reg) begin
            init_val = ((n_reg - base_reg) < size_reg) ? (n_reg - base_reg) : size_reg;
        end else begin
            init_val = '0;
        end
    end

    assign base_end = base_reg + size_reg;

    always_comb begin
        n_next    = n_reg;
        idx_next  = idx_reg;
        base_next = base_reg;
        size_next = size_reg;
        if (cfg_fire) begin
            n_next    = (cfg_slot_count > CFG_W'(SLOTS)) ? CNT_W'(SLOTS)
                                                         : CNT_W'(cfg_slot_count);
            idx_next  = NODE_W'(1);
            base_next = '0;
            size_next = CNT_W'(SLOTS);
        end else if (cmd.clr_step) begin
            idx_next = idx_reg + NODE_W'(1);
            if (base_end == CNT_W'(SLOTS)) begin
                base_next = '0;
                size_next = size_reg >> 1;
            end else begin
                base_next = base_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg    <= CNT_W'(SLOTS);
            idx_reg  <= NODE_W'(1);
            base_reg <= '0;
            size_reg <= CNT_W'(SLOTS);
        end else begin
            n_reg    <= n_next;
            idx_reg  <= idx_next;
            base_reg <= base_next;
            size_reg <= size_next;
        end
    end

    // memory ports
    assign mem_we    = cmd.clr_step | cmd.step_write;
    assign mem_waddr = cmd.clr_step ? idx_reg : node_reg;
    assign mem_wdata = cmd.clr_step ? init_val : (cur_reg - CNT_W'(1));
    assign mem_re    = cmd.load_item | cmd.read_left;
    assign mem_raddr = cmd.load_item ? NODE_W'(1) : {node_reg[NODE_W-2:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tree_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= tree_mem[mem_raddr];
        end
    end

    // descent
    assign go_left = (k_reg < rd_data_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            k_reg <= CNT_W'(s_rank);
        end else if (cmd.descend && !go_left) begin
            k_reg <= k_reg - rd_data_reg;
        end
        if (cmd.take_root) begin
            node_reg  <= NODE_W'(1);
            cur_reg   <= rd_data_reg;
            total_reg <= rd_data_reg;
            fault_reg <= !go_left;
        end else if (cmd.descend) begin
            node_reg <= {node_reg[NODE_W-2:0], !go_left};
            cur_reg  <= go_left ? rd_data_reg : (cur_reg - rd_data_reg);
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_slot_reg      <= fault_reg ? '0 : SLOT_W'(node_reg[LEVELS-1:0]);
            m_fault_reg     <= fault_reg;
            m_free_left_reg <= fault_reg ? FREE_W'(total_reg)
                                         : FREE_W'(total_reg - CNT_W'(1));
        end
    end

    assign sts.clr_last  = (idx_reg == NODE_W'(TREE_LEN - 1));
    assign sts.over_rank = !go_left;
    assign sts.at_leaf   = node_reg[LEVELS];
    assign sts.out_busy  = m_valid_reg && !m_ready;

    assign m_valid     = m_valid_reg;
    assign m_slot      = m_slot_reg;
    assign m_fault     = m_fault_reg;
    assign m_free_left = m_free_left_reg;

endmodule

[rtl/kth_free_slot_allocator.sv]
// kth_free_slot_allocator: top level joining sequencer and datapath
// depends on kfsa_pkg, kfsa_ctrl, kfsa_dp
`timescale 1ns / 1ps

//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  cfg      | in        | cfg_valid/cfg_ready | cfg_slot_count[10:0]
//  s        | in        | s_valid/s_ready     | s_rank[9:0]
//  m        | out       | m_valid/m_ready     | m_slot[9:0] m_fault m_free_left[10:0]
//
//  one beat at a time: once a rank beat is taken the sequencer reads the root,
//  checks the rank, then on each of the 10 levels writes the node and then
//  reads its left child through the registered read port, and at the end writes
//  the leaf and loads the result
//  a rank beat that faults skips the descent and loads the result after the check
//  after reset and after every cfg beat a sweep rewrites tree entries 1 to 2047;
//  s_ready stays low meanwhile, cfg_ready stays high
//  the result register frees the sequencer: the next rank beat is taken
//  while a result still waits on m_ready, and its walk holds at the end
//  until the result register empties

module kth_free_slot_allocator
    import kfsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // register write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_slot_count,
    // rank beats
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [RANK_W-1:0] s_rank,
    // results
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SLOT_W-1:0] m_slot,
    output logic              m_fault,
    output logic [FREE_W-1:0] m_free_left
);

    kfsa_cmd_t cmd;
    kfsa_sts_t sts;
    logic      cfg_fire;

    // register writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    kfsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .cfg_fire (cfg_fire),
        .sts      (sts),
        .s_ready  (s_ready),
        .cmd      (cmd)
    );

    kfsa_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_fire       (cfg_fire),
        .cfg_slot_count (cfg_slot_count),
        .s_rank         (s_rank),
        .m_ready        (m_ready),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_slot         (m_slot),
        .m_fault        (m_fault),
        .m_free_left    (m_free_left)
    );

endmodule

[rtl/kfsa_chk.sv]
// kfsa_chk: port level checks for the allocator, bound to the top level
// depends on kfsa_pkg and kth_free_slot_allocator
`timescale 1ns / 1ps

module kfsa_chk
    import kfsa_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [SLOT_W-1:0] m_slot,
    input logic              m_fault,
    input logic [FREE_W-1:0] m_free_left
);

    // result register is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one beat in flight: no new rank beat right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("rank beat taken back to back");

    // a fault reports slot zero
    a_fault_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fault) |-> (m_slot == '0))
        else $error("fault with nonzero slot");

    // a taken slot leaves fewer than all slots free
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_fault) |-> (m_free_left < FREE_W'(SLOTS)))
        else $error("free count too large after a take");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_slot) && $stable(m_fault)
                                   && $stable(m_free_left)))
        else $error("stalled result changed");

endmodule

bind kth_free_slot_allocator kfsa_chk u_kfsa_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_slot      (m_slot),
    .m_fault     (m_fault),
    .m_free_left (m_free_left)
);
